// ===== design/ictw_pkg.sv =====
// Package for the idle-connection timing wheel.
// Holds operation and result codes, the scan state type and the wheel slot function.
// No dependencies.
package ictw_pkg;

  localparam int WHEEL_SLOTS = 30;
  localparam int SLOT_W      = 5;
  localparam int TIME_W      = 32;
  localparam int ID_PORT_W   = 6;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_TOUCH  = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [1:0] RK_DONE    = 2'd0;
  localparam logic [1:0] RK_EXPIRED = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;
  localparam logic [1:0] RK_NONE    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EV   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // time mod 30: nibble sum gives mod 15, bit 0 gives mod 2, then combine
  function automatic logic [SLOT_W-1:0] slot_of(input logic [TIME_W-1:0] t);
    logic [6:0] nsum;
    logic [4:0] fold;
    logic [3:0] r15;
    nsum = '0;
    for (int k = 0; k < 8; k++) begin
      nsum = nsum + 7'(t[4*k +: 4]);
    end
    fold = 5'(nsum[6:4]) + 5'(nsum[3:0]);
    r15  = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];
    return (r15[0] == t[0]) ? 5'(r15) : 5'(r15) + 5'd15;
  endfunction

endpackage

// ===== design/idle_connection_timing_wheel.sv =====
// Top level of the idle-connection timing wheel.
// Depends on ictw_pkg and ictw_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one word: kind, conn_id, now_sec.
//   Result channel (out_valid/out_stall) returns words of result_kind,
//   expired_id and last_result; last_result marks the final word of an item.
//   Insert, touch and remove are decided from the per-id present bits;
//   insert and touch write last-seen time and wheel slot into one RAM. Each
//   op's single result word appears in the output register the next cycle.
//   A tick scans every id: a RAM read state and an evaluate state per id,
//   then a finish state that sends the last word. Expired ids
//   come out in ascending order; one expiry is held back so that the last
//   word can carry last_result, or a found-none word is sent.
//   The input stalls while a tick scans and while the output register is
//   full and stalled. A stalled result holds its value; the scan pauses only to send a word.
//   Reset clears the present bits, the output valid bit and the scan state;
//   RAM contents are not cleared, and their read data is used only for present ids.
module idle_connection_timing_wheel
  import ictw_pkg::*;
#(
  parameter int MAX_CONN    = 64,
  parameter int TIMEOUT_SEC = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [ID_PORT_W-1:0] in_conn_id,
  input  logic [TIME_W-1:0]    in_now_sec,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [ID_PORT_W-1:0] out_expired_id,
  output logic                 out_last_result
);

  localparam int ID_W  = $clog2(MAX_CONN);
  localparam int MEM_W = TIME_W + SLOT_W;

  state_t                 state_r, state_nxt;
  logic [MAX_CONN-1:0]    present_r, present_nxt;
  logic [ID_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic [TIME_W-1:0]      tick_now_r, tick_now_nxt;
  logic [SLOT_W-1:0]      tick_slot_r, tick_slot_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]        pend_id_r, pend_id_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic [ID_PORT_W-1:0]   out_id_r, out_id_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   can_load;
  logic                   accept;
  logic                   in_range;
  logic                   pres;
  logic                   op_err;
  logic [SLOT_W-1:0]      in_slot;
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [MEM_W-1:0]       ram_rd_data;
  logic [TIME_W-1:0]      rd_last;
  logic [SLOT_W-1:0]      rd_slot;
  logic                   hit;
  logic                   blocked;
  logic                   scan_end;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !can_load;
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, in_conn_id} < 7'(MAX_CONN);
  assign pres     = in_range && present_r[in_conn_id[ID_W-1:0]];
  assign in_slot  = slot_of(in_now_sec);

  always_comb begin
    case (in_kind)
      KIND_INSERT: op_err = !in_range || pres;
      default:     op_err = !pres;
    endcase
  end

  assign ram_wr_en = accept && !op_err &&
                     (in_kind == KIND_INSERT || in_kind == KIND_TOUCH);
  assign ram_rd_en = (state_r == ST_RD);

  ictw_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_CONN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_conn_id[ID_W-1:0]),
    .wr_data ({in_now_sec, in_slot}),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rd_data)
  );

  assign rd_last  = ram_rd_data[MEM_W-1:SLOT_W];
  assign rd_slot  = ram_rd_data[SLOT_W-1:0];
  assign hit      = present_r[scan_idx_r] && (rd_slot == tick_slot_r) &&
                    ((tick_now_r - rd_last) >= TIME_W'(TIMEOUT_SEC));
  assign blocked  = hit && pend_valid_r && !can_load;
  assign scan_end = (scan_idx_r == ID_W'(MAX_CONN - 1));

  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    scan_idx_nxt   = scan_idx_r;
    tick_now_nxt   = tick_now_r;
    tick_slot_nxt  = tick_slot_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TICK) begin
            tick_now_nxt  = in_now_sec;
            tick_slot_nxt = in_slot;
            scan_idx_nxt  = '0;
            state_nxt     = ST_RD;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = op_err ? RK_ERROR : RK_DONE;
            out_id_nxt    = '0;
            out_last_nxt  = 1'b1;
            if (!op_err && in_kind == KIND_INSERT) begin
              present_nxt[in_conn_id[ID_W-1:0]] = 1'b1;
            end
            if (!op_err && in_kind == KIND_REMOVE) begin
              present_nxt[in_conn_id[ID_W-1:0]] = 1'b0;
            end
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EV;
      end
      ST_EV: begin
        if (!blocked) begin
          if (hit) begin
            present_nxt[scan_idx_r] = 1'b0;
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = RK_EXPIRED;
              out_id_nxt    = ID_PORT_W'(pend_id_r);
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = scan_idx_r;
          end
          if (scan_end) begin
            state_nxt = ST_FIN;
          end else begin
            scan_idx_nxt = scan_idx_r + ID_W'(1);
            state_nxt    = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_valid_r ? RK_EXPIRED : RK_NONE;
          out_id_nxt     = pend_valid_r ? ID_PORT_W'(pend_id_r) : '0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          scan_idx_nxt   = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      present_r    <= '0;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_now_r  <= tick_now_nxt;
    tick_slot_r <= tick_slot_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_expired_id  = out_id_r;
  assign out_last_result = out_last_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r && scan_idx_r == '0)
    else $error("pending expiry or scan index left over in idle");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EV && hit && !blocked |=> !present_r[$past(scan_idx_r)])
    else $error("expired id still present after evaluation");

  a_op_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind != KIND_TICK |=> out_valid && out_last_result)
    else $error("single-result word not delivered after accept");

  a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && can_load |=> out_valid && out_last_result &&
    state_r == ST_IDLE)
    else $error("tick scan did not finish with a last word");

endmodule

// ===== design/ictw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ictw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== test/idle_connection_timing_wheel_tb.sv =====
// Testbench for idle_connection_timing_wheel: directed table, then random connection traffic
// checked word by word against a predictor of the wheel. Depends on ictw_pkg and the RTL.
`timescale 1ns / 1ps

module idle_connection_timing_wheel_tb;
  import ictw_pkg::*;

  localparam int CONN_COUNT = 64;
  localparam int IDLE_LIMIT = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 132;
  localparam int DRAIN_CYCLES = 2 * CONN_COUNT + 8;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_PORT_W-1:0] conn_id;
    logic [TIME_W-1:0]    now_sec;
  } conn_word_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [ID_PORT_W-1:0] expired_id;
    logic                 last_result;
  } wheel_result_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_PORT_W-1:0] conn_id;
    logic [TIME_W-1:0]    now_sec;
    logic                 typed;
    logic [1:0]           result_kind;
  } script_row_t;

  localparam int SCRIPT_LEN = 24;

  script_row_t script [SCRIPT_LEN] = '{
    '{KIND_TICK,   6'd17, 32'd0,          1'b1, RK_NONE},
    '{KIND_TOUCH,  6'd5,  32'd0,          1'b1, RK_ERROR},
    '{KIND_REMOVE, 6'd63, 32'd0,          1'b1, RK_ERROR},
    '{KIND_INSERT, 6'd0,  32'd0,          1'b1, RK_DONE},
    '{KIND_INSERT, 6'd0,  32'd1,          1'b1, RK_ERROR},
    '{KIND_INSERT, 6'd63, 32'd0,          1'b1, RK_DONE},
    '{KIND_TOUCH,  6'd63, 32'd10,         1'b1, RK_DONE},
    '{KIND_TICK,   6'd0,  32'd29,         1'b0, RK_NONE},
    '{KIND_TICK,   6'd63, 32'd30,         1'b0, RK_NONE},
    '{KIND_TICK,   6'd0,  32'd40,         1'b0, RK_NONE},
    '{KIND_INSERT, 6'd63, 32'd31,         1'b1, RK_DONE},
    '{KIND_REMOVE, 6'd63, 32'd31,         1'b1, RK_DONE},
    '{KIND_REMOVE, 6'd63, 32'd32,         1'b1, RK_ERROR},
    '{KIND_INSERT, 6'd1,  32'hFFFF_FFFF,  1'b1, RK_DONE},
    '{KIND_TICK,   6'd42, 32'd15,         1'b0, RK_NONE},
    '{KIND_TICK,   6'd21, 32'd45,         1'b0, RK_NONE},
    '{KIND_INSERT, 6'd2,  32'd100,        1'b1, RK_DONE},
    '{KIND_TICK,   6'd0,  32'd70,         1'b0, RK_NONE},
    '{KIND_INSERT, 6'd10, 32'd200,        1'b1, RK_DONE},
    '{KIND_INSERT, 6'd20, 32'd200,        1'b1, RK_DONE},
    '{KIND_INSERT, 6'd40, 32'd200,        1'b1, RK_DONE},
    '{KIND_TOUCH,  6'd20, 32'd229,        1'b1, RK_DONE},
    '{KIND_TICK,   6'd0,  32'd230,        1'b0, RK_NONE},
    '{KIND_TICK,   6'd63, 32'd259,        1'b0, RK_NONE}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind = '0;
  logic [ID_PORT_W-1:0] in_conn_id = '0;
  logic [TIME_W-1:0]    in_now_sec = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_result_kind;
  logic [ID_PORT_W-1:0] out_expired_id;
  logic                 out_last_result;

  logic                 live [CONN_COUNT];
  logic [TIME_W-1:0]    seen_sec [CONN_COUNT];
  logic [SLOT_W-1:0]    seen_slot [CONN_COUNT];
  wheel_result_t        due_results [$];
  int                   mismatches = 0;
  int                   send_idle_pct = 0;
  int                   stall_idle_pct = 0;
  int                   idle_mode = 0;
  int                   hold_left = 0;
  logic                 hold_done = 1'b0;
  logic [TIME_W-1:0]    wall_sec;

  idle_connection_timing_wheel #(
    .MAX_CONN    (CONN_COUNT),
    .TIMEOUT_SEC (IDLE_LIMIT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_conn_id      (in_conn_id),
    .in_now_sec      (in_now_sec),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_expired_id  (out_expired_id),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("idle_connection_timing_wheel regression: fail");
    $finish;
  end

  function automatic void post_result(input logic [1:0] rk, input logic [ID_PORT_W-1:0] id,
                                      input logic last);
    wheel_result_t r;
    r.result_kind = rk;
    r.expired_id  = id;
    r.last_result = last;
    due_results.push_back(r);
  endfunction

  function automatic void wheel_predict(input conn_word_t w);
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] elapsed;
    wheel_result_t     r;
    int                n;
    slot = SLOT_W'(w.now_sec % WHEEL_SLOTS);
    n = 0;
    if (w.kind == KIND_TICK) begin
      for (int i = 0; i < CONN_COUNT; i++) begin
        elapsed = w.now_sec - seen_sec[i];
        if (live[i] && seen_slot[i] == slot && elapsed >= IDLE_LIMIT) begin
          live[i] = 1'b0;
          post_result(RK_EXPIRED, ID_PORT_W'(i), 1'b0);
          n++;
        end
      end
      if (n == 0) begin
        post_result(RK_NONE, '0, 1'b1);
      end else begin
        r = due_results.pop_back();
        r.last_result = 1'b1;
        due_results.push_back(r);
      end
    end else if (w.kind == KIND_INSERT) begin
      if (live[w.conn_id]) begin
        post_result(RK_ERROR, '0, 1'b1);
      end else begin
        live[w.conn_id] = 1'b1;
        seen_sec[w.conn_id] = w.now_sec;
        seen_slot[w.conn_id] = slot;
        post_result(RK_DONE, '0, 1'b1);
      end
    end else if (!live[w.conn_id]) begin
      post_result(RK_ERROR, '0, 1'b1);
    end else begin
      if (w.kind == KIND_TOUCH) begin
        seen_sec[w.conn_id] = w.now_sec;
        seen_slot[w.conn_id] = slot;
      end else begin
        live[w.conn_id] = 1'b0;
      end
      post_result(RK_DONE, '0, 1'b1);
    end
  endfunction

  // Check one accepted result word against the oldest expectation.
  function automatic void check_result();
    wheel_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result word: result_kind %0d expired_id %0d last_result %0b",
             out_result_kind, out_expired_id, out_last_result);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (out_result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, out_result_kind);
      mismatches++;
    end
    if (out_expired_id !== want.expired_id) begin
      $error("expired_id: expected %0d, got %0d", want.expired_id, out_expired_id);
      mismatches++;
    end
    if (out_last_result !== want.last_result) begin
      $error("last_result: expected %0b, got %0b", want.last_result, out_last_result);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (idle_mode == 2 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_idle_pct);
    end
  end

  task automatic set_idling(input int mode);
    idle_mode = mode;
    case (mode)
      0: begin
        send_idle_pct = 28;
        stall_idle_pct = 77;
      end
      1: begin
        send_idle_pct = 77;
        stall_idle_pct = 28;
      end
      default: begin
        send_idle_pct = 0;
        stall_idle_pct = 0;
      end
    endcase
  endtask

  task automatic idle_gap();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one word, hold it until accepted, then predict its results.
  task automatic send_word(input conn_word_t w, input logic typed, input logic [1:0] rk);
    int base;
    in_valid   <= 1'b1;
    in_kind    <= w.kind;
    in_conn_id <= w.conn_id;
    in_now_sec <= w.now_sec;
    do @(posedge clk); while (in_stall);
    base = due_results.size();
    wheel_predict(w);
    if (typed) begin
      while (due_results.size() > base) void'(due_results.pop_back());
      post_result(rk, '0, 1'b1);
    end
  endtask

  task automatic pick_word(output conn_word_t w);
    int r;
    int id;
    r = $urandom_range(0, 99);
    id = $urandom_range(0, CONN_COUNT - 1);
    w.now_sec = wall_sec;
    w.conn_id = ID_PORT_W'(id);
    if (r < 12) begin
      w.kind = 2'($urandom);
      w.conn_id = ID_PORT_W'($urandom);
      if ($urandom_range(0, 1) == 1) w.now_sec = $urandom;
    end else if (r < 55) begin
      w.kind = KIND_TICK;
      w.conn_id = ID_PORT_W'($urandom);
      if ($urandom_range(0, 9) == 0) wall_sec = wall_sec + $urandom_range(2, 40);
      else wall_sec = wall_sec + 1;
    end else if (!live[id]) begin
      w.kind = KIND_INSERT;
    end else if ($urandom_range(0, 9) < 7) begin
      w.kind = KIND_TOUCH;
    end else begin
      w.kind = KIND_REMOVE;
    end
  endtask

  initial begin
    conn_word_t w;
    for (int i = 0; i < CONN_COUNT; i++) begin
      live[i] = 1'b0;
      seen_sec[i] = '0;
      seen_slot[i] = '0;
    end
    set_idling(0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      w.kind    = script[k].kind;
      w.conn_id = script[k].conn_id;
      w.now_sec = script[k].now_sec;
      idle_gap();
      send_word(w, script[k].typed, script[k].result_kind);
    end

    for (int mode = 0; mode < 3; mode++) begin
      set_idling(mode);
      wall_sec = (mode == 1) ? 32'hFFFF_FF80 + $urandom_range(0, 63) : $urandom;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick_word(w);
        idle_gap();
        send_word(w, 1'b0, RK_DONE);
      end
    end
    in_valid <= 1'b0;

    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("idle_connection_timing_wheel regression: pass");
    end else begin
      $display("idle_connection_timing_wheel regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ictw_pkg.sv
design/ictw_ram.sv
design/idle_connection_timing_wheel.sv
test/idle_connection_timing_wheel_tb.sv
